### rtl/core/kwl_pkg.sv
package kwl_pkg;

  localparam int COEF_W         = 32;
  localparam int COEF_FRAC_BITS = 28;
  localparam int OUT_BITS       = 26;
  localparam int ENERGY_W       = 52;
  localparam int OUT_TW         = 56;
  localparam int CFG_IDX_W      = 3;

  localparam logic signed [COEF_W-1:0] SHELF_B0_RST    = 32'sd412081942;
  localparam logic signed [COEF_W-1:0] SHELF_B1_RST    = -32'sd722546694;
  localparam logic signed [COEF_W-1:0] SHELF_B2_RST    = 32'sd321691121;
  localparam logic signed [COEF_W-1:0] SHELF_A1_RST    = -32'sd453832898;
  localparam logic signed [COEF_W-1:0] SHELF_A2_RST    = 32'sd196623811;
  localparam logic signed [COEF_W-1:0] HIGHPASS_A1_RST = -32'sd534199296;
  localparam logic signed [COEF_W-1:0] HIGHPASS_A2_RST = 32'sd265770497;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHELF_B0    = 3'd0,
    REG_SHELF_B1    = 3'd1,
    REG_SHELF_B2    = 3'd2,
    REG_SHELF_A1    = 3'd3,
    REG_SHELF_A2    = 3'd4,
    REG_HIGHPASS_A1 = 3'd5,
    REG_HIGHPASS_A2 = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MS_B0_X    = 3'd0,
    MS_B1_X1   = 3'd1,
    MS_B2_X2   = 3'd2,
    MS_A1_S1   = 3'd3,
    MS_A2_S2   = 3'd4,
    MS_HA1_H1  = 3'd5,
    MS_HA2_H2  = 3'd6,
    MS_SQUARE  = 3'd7
  } mul_sel_t;

  typedef struct packed {
    logic     in_load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_clr;
    logic     acc_init;
    logic     s_latch;
    logic     h_latch;
    logic     swap;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic prod_pending;
  } status_t;

endpackage

### rtl/core/kwl_ctrl.sv
module kwl_ctrl
  import kwl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_SHELF  = 11'b000_0000_0010,
    ST_SDRAIN = 11'b000_0000_0100,
    ST_SFIN   = 11'b000_0000_1000,
    ST_HPINIT = 11'b000_0001_0000,
    ST_HP     = 11'b000_0010_0000,
    ST_HDRAIN = 11'b000_0100_0000,
    ST_HFIN   = 11'b000_1000_0000,
    ST_SQUARE = 11'b001_0000_0000,
    ST_EDRAIN = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;
  logic       ch, ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ch    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ch    <= ch_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ch_next    = ch;
    cmd        = '0;
    cmd.mul_sel = MS_B0_X;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.in_load = 1'b1;
          cmd.acc_clr = 1'b1;
          cnt_next    = '0;
          ch_next     = 1'b0;
          state_next  = ST_SHELF;
        end
      end
      ST_SHELF: begin
        cmd.mul_en = 1'b1;
        unique case (cnt)
          3'd0:    cmd.mul_sel = MS_B0_X;
          3'd1:    cmd.mul_sel = MS_B1_X1;
          3'd2:    cmd.mul_sel = MS_B2_X2;
          3'd3:    cmd.mul_sel = MS_A1_S1;
          default: cmd.mul_sel = MS_A2_S2;
        endcase
        if (cnt == 3'd4) begin
          state_next = ST_SDRAIN;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_SDRAIN: state_next = ST_SFIN;
      ST_SFIN: begin
        cmd.s_latch = 1'b1;
        state_next  = ST_HPINIT;
      end
      ST_HPINIT: begin
        cmd.acc_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_HP;
      end
      ST_HP: begin
        cmd.mul_en = 1'b1;
        if (cnt == 3'd0) begin
          cmd.mul_sel = MS_HA1_H1;
          cnt_next    = 3'd1;
        end else begin
          cmd.mul_sel = MS_HA2_H2;
          state_next  = ST_HDRAIN;
        end
      end
      ST_HDRAIN: state_next = ST_HFIN;
      ST_HFIN: begin
        cmd.h_latch = 1'b1;
        state_next  = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_SQUARE;
        cmd.swap    = 1'b1;
        cmd.acc_clr = 1'b1;
        if (!ch) begin
          ch_next    = 1'b1;
          cnt_next   = '0;
          state_next = ST_SHELF;
        end else begin
          state_next = ST_EDRAIN;
        end
      end
      ST_EDRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/core/kwl_datapath.sv
module kwl_datapath
  import kwl_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                sts,
  input  logic [2*SAMPLE_BITS-1:0] in_pair,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COEF_W-1:0]      cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ENERGY_W-1:0]    out_energy
);

  localparam int DW    = (SAMPLE_BITS > OUT_BITS) ? SAMPLE_BITS : OUT_BITS;
  localparam int PW    = COEF_W + DW;
  localparam int ACC_W = PW + 4;
  localparam int HW    = OUT_BITS + 2;
  localparam int RW    = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
  localparam logic signed [RW-1:0] SAT_HI = RW'((2 ** (OUT_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-(2 ** (OUT_BITS - 1)));

  logic signed [COEF_W-1:0] shelf_b0, shelf_b1, shelf_b2, shelf_a1, shelf_a2;
  logic signed [COEF_W-1:0] highpass_a1, highpass_a2;

  logic signed [SAMPLE_BITS-1:0] x_now, x_next;
  logic signed [SAMPLE_BITS-1:0] x1_cur, x2_cur, x1_oth, x2_oth;
  logic signed [OUT_BITS-1:0]    s1_cur, s2_cur, s1_oth, s2_oth;
  logic signed [OUT_BITS-1:0]    h1_cur, h2_cur, h1_oth, h2_oth;
  logic signed [OUT_BITS-1:0]    s_reg, h_reg;

  logic signed [COEF_W-1:0] op_a;
  logic signed [DW-1:0]     op_b;
  logic signed [PW-1:0]     prod;
  logic                     prod_acc, prod_sub, prod_sq;
  logic signed [ACC_W-1:0]  acc;
  logic [ENERGY_W-1:0]      energy;

  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [RW-1:0]       rnd;
  logic signed [OUT_BITS-1:0] rnd_sat;
  logic signed [HW-1:0]       hp_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      shelf_b0    <= SHELF_B0_RST;
      shelf_b1    <= SHELF_B1_RST;
      shelf_b2    <= SHELF_B2_RST;
      shelf_a1    <= SHELF_A1_RST;
      shelf_a2    <= SHELF_A2_RST;
      highpass_a1 <= HIGHPASS_A1_RST;
      highpass_a2 <= HIGHPASS_A2_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SHELF_B0:    shelf_b0    <= cfg_data;
        REG_SHELF_B1:    shelf_b1    <= cfg_data;
        REG_SHELF_B2:    shelf_b2    <= cfg_data;
        REG_SHELF_A1:    shelf_a1    <= cfg_data;
        REG_SHELF_A2:    shelf_a2    <= cfg_data;
        REG_HIGHPASS_A1: highpass_a1 <= cfg_data;
        REG_HIGHPASS_A2: highpass_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MS_B0_X:   begin op_a = shelf_b0;    op_b = DW'(x_now);  end
      MS_B1_X1:  begin op_a = shelf_b1;    op_b = DW'(x1_cur); end
      MS_B2_X2:  begin op_a = shelf_b2;    op_b = DW'(x2_cur); end
      MS_A1_S1:  begin op_a = shelf_a1;    op_b = DW'(s1_cur); end
      MS_A2_S2:  begin op_a = shelf_a2;    op_b = DW'(s2_cur); end
      MS_HA1_H1: begin op_a = highpass_a1; op_b = DW'(h1_cur); end
      MS_HA2_H2: begin op_a = highpass_a2; op_b = DW'(h2_cur); end
      default:   begin op_a = COEF_W'(h_reg); op_b = DW'(h_reg); end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PW'(op_a) * PW'(op_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_acc <= 1'b0;
      prod_sq  <= 1'b0;
      prod_sub <= 1'b0;
    end else begin
      prod_acc <= cmd.mul_en && (cmd.mul_sel != MS_SQUARE);
      prod_sq  <= cmd.mul_en && (cmd.mul_sel == MS_SQUARE);
      prod_sub <= (cmd.mul_sel == MS_A1_S1) || (cmd.mul_sel == MS_A2_S2) ||
                  (cmd.mul_sel == MS_HA1_H1) || (cmd.mul_sel == MS_HA2_H2);
    end
  end

  assign acc_rnd = acc + HALF;
  assign rnd     = RW'(acc_rnd >>> COEF_FRAC_BITS);

  always_comb begin
    if (rnd > SAT_HI) begin
      rnd_sat = OUT_BITS'(SAT_HI);
    end else if (rnd < SAT_LO) begin
      rnd_sat = OUT_BITS'(SAT_LO);
    end else begin
      rnd_sat = OUT_BITS'(rnd);
    end
  end

  assign hp_sum = HW'(s_reg) - (HW'(s1_cur) <<< 1) + HW'(s2_cur);

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_init) begin
      acc <= ACC_W'(hp_sum) <<< COEF_FRAC_BITS;
    end else if (prod_acc) begin
      if (prod_sub) begin
        acc <= acc - ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.s_latch) s_reg <= rnd_sat;
    if (cmd.h_latch) h_reg <= rnd_sat;
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      energy <= '0;
    end else if (prod_sq) begin
      energy <= energy + prod[ENERGY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      x_now  <= in_pair[SAMPLE_BITS-1:0];
      x_next <= in_pair[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end else if (cmd.swap) begin
      x_now <= x_next;
    end
  end

  // rotate channel histories so the active channel always sits in the _cur slots
  always_ff @(posedge clk) begin
    if (rst) begin
      x1_cur <= '0; x2_cur <= '0; x1_oth <= '0; x2_oth <= '0;
      s1_cur <= '0; s2_cur <= '0; s1_oth <= '0; s2_oth <= '0;
      h1_cur <= '0; h2_cur <= '0; h1_oth <= '0; h2_oth <= '0;
    end else if (cmd.swap) begin
      x1_cur <= x1_oth; x2_cur <= x2_oth; x1_oth <= x_now; x2_oth <= x1_cur;
      s1_cur <= s1_oth; s2_cur <= s2_oth; s1_oth <= s_reg; s2_oth <= s1_cur;
      h1_cur <= h1_oth; h2_cur <= h2_oth; h1_oth <= h_reg; h2_oth <= h1_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_energy <= energy;
  end

  assign sts.out_free     = !out_valid || out_ready;
  assign sts.prod_pending = prod_acc;

endmodule

### rtl/core/k_weighting_loudness_prefilter.sv
// K-weighting prefilter for loudness measurement, one stereo pair per transaction.
// Slave channel (s_*): tdata carries left_sample then right_sample, each
// SAMPLE_BITS wide, padded with zeros to whole bytes.
// Master channel (m_*): tdata carries the 52-bit energy hl*hl + hr*hr.
// Configuration channel (cfg_*): cfg_index selects one of the seven Q3.28
// coefficients, cfg_data carries its value; an index of 7 is dropped.
// cfg_ready is always high; write only while no pair is in flight.
// Each channel runs a high-shelf biquad and a high-pass biquad on a single
// multiply-accumulate unit, sequenced by a state machine.
// One pair is processed at a time: each channel puts its 8 products through
// the shared multiplier with pipeline drains and rounding, then the energy
// sum is finished, and the result is loaded into the output register once
// that register is free, after which the block is idle again.
// s_tready is high only while idle; the result sits in the output register
// and the next pair may be taken while m_tvalid waits on m_tready. A pair that
// finishes while the previous result is still held waits for it to drain.
// Reset clears the filter histories, loads the default coefficients and
// empties the output register.
module k_weighting_loudness_prefilter
  import kwl_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [SAMPLE_BITS-1:0] left_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_sample
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [51:0] energy, [55:52] zero
  output logic [OUT_TW-1:0]    m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  cmd_t                cmd;
  status_t             sts;
  logic [ENERGY_W-1:0] energy;

  assign cfg_ready = 1'b1;

  kwl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kwl_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_pair    (s_tdata[2*SAMPLE_BITS-1:0]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_energy (energy)
  );

  assign m_tdata = {{(OUT_TW - ENERGY_W){1'b0}}, energy};

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_one_pair: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second pair taken while a pair is in flight");

  a_round_drained: assert property (@(posedge clk) disable iff (rst)
    (cmd.s_latch || cmd.h_latch || cmd.acc_init) |-> !sts.prod_pending)
    else $error("accumulator read or loaded with a product in flight");

  a_load_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !cmd.out_load)
    else $error("result loaded straight after a pair was taken");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb
  import kwl_pkg::*;
();

  localparam int SB = 24;
  localparam int TDATA_W = ((2 * SB + 7) / 8) * 8;
  localparam int NUM_REGS = 7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int END_SETTLE = 60;
  localparam int ERR_PRINT_MAX = 40;
  localparam int RANDOM_MODES = 4;
  localparam int SETS_PER_MODE = 4;
  localparam int PAIRS_PER_SET = 112;

  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB - 1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB - 1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_HALF = 32'sd134217728;

  localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (OUT_BITS - 1)) - 1;
  localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< (OUT_BITS - 1));

  typedef logic [NUM_REGS-1:0][COEF_W-1:0] coef_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TW-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  coef_set_t active_coefs;
  logic signed [SB-1:0] shelf_in_hist [4];
  logic signed [OUT_BITS-1:0] shelf_out_hist [4];
  logic signed [OUT_BITS-1:0] hp_out_hist [4];
  logic [ENERGY_W-1:0] energy_q [$];
  logic [ENERGY_W-1:0] expected_energy;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_kick = 0;
  int seen_kick = 0;
  int hold_left = 0;
  int pairs_sent = 0;
  int energies_checked = 0;
  int coef_loads = 0;
  int error_count = 0;

  k_weighting_loudness_prefilter #(
    .SAMPLE_BITS(SB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic signed [OUT_BITS-1:0] round_sat(input logic signed [127:0] acc);
    logic signed [127:0] q;
    q = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q[OUT_BITS-1:0];
  endfunction

  function automatic logic signed [OUT_BITS-1:0] k_weight(input int ch,
                                                         input logic signed [SB-1:0] x);
    logic signed [127:0] acc;
    logic signed [OUT_BITS-1:0] s;
    logic signed [OUT_BITS-1:0] h;
    int i;
    i = ch * 2;
    acc = $signed(active_coefs[REG_SHELF_B0]) * x
        + $signed(active_coefs[REG_SHELF_B1]) * shelf_in_hist[i]
        + $signed(active_coefs[REG_SHELF_B2]) * shelf_in_hist[i+1]
        - $signed(active_coefs[REG_SHELF_A1]) * shelf_out_hist[i]
        - $signed(active_coefs[REG_SHELF_A2]) * shelf_out_hist[i+1];
    s = round_sat(acc);
    acc = 128'(s);
    acc = acc - shelf_out_hist[i] - shelf_out_hist[i] + shelf_out_hist[i+1];
    acc = acc <<< COEF_FRAC_BITS;
    acc = acc - $signed(active_coefs[REG_HIGHPASS_A1]) * hp_out_hist[i]
              - $signed(active_coefs[REG_HIGHPASS_A2]) * hp_out_hist[i+1];
    h = round_sat(acc);
    shelf_in_hist[i+1] = shelf_in_hist[i];
    shelf_in_hist[i] = x;
    shelf_out_hist[i+1] = shelf_out_hist[i];
    shelf_out_hist[i] = s;
    hp_out_hist[i+1] = hp_out_hist[i];
    hp_out_hist[i] = h;
    return h;
  endfunction

  function automatic logic [ENERGY_W-1:0] stereo_energy(input logic signed [SB-1:0] l,
                                                        input logic signed [SB-1:0] r);
    logic signed [OUT_BITS-1:0] hl;
    logic signed [OUT_BITS-1:0] hr;
    logic signed [127:0] sq;
    hl = k_weight(0, l);
    hr = k_weight(1, r);
    sq = hl * hl + hr * hr;
    return sq[ENERGY_W-1:0];
  endfunction

  function automatic coef_set_t default_coefs();
    coef_set_t c;
    c[REG_SHELF_B0] = SHELF_B0_RST;
    c[REG_SHELF_B1] = SHELF_B1_RST;
    c[REG_SHELF_B2] = SHELF_B2_RST;
    c[REG_SHELF_A1] = SHELF_A1_RST;
    c[REG_SHELF_A2] = SHELF_A2_RST;
    c[REG_HIGHPASS_A1] = HIGHPASS_A1_RST;
    c[REG_HIGHPASS_A2] = HIGHPASS_A2_RST;
    return c;
  endfunction

  // kind: 0 defaults, 1 defaults nudged, 2 anything, 3 rails
  function automatic coef_set_t make_coefs(input int kind);
    coef_set_t c;
    int i;
    c = default_coefs();
    for (i = 0; i < NUM_REGS; i++) begin
      case (kind)
        1: c[i] = $signed(c[i]) + $signed(32'($urandom_range(0, 2 ** 21))) - 32'sd1048576;
        2: c[i] = $urandom();
        3: c[i] = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
        default: ;
      endcase
    end
    return c;
  endfunction

  function automatic logic signed [SB-1:0] rand_sample();
    logic signed [SB-1:0] v;
    v = SB'($urandom());
    case ($urandom_range(0, 9))
      5, 6: v = SB'($urandom_range(0, 255)) - SB'(128);
      7: case ($urandom_range(0, 4))
        0: v = SAMPLE_MAX;
        1: v = SAMPLE_MIN;
        2: v = '0;
        3: v = '1;
        default: v = SB'(1);
      endcase
      8, 9: v = v >>> $urandom_range(0, SB - 2);
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    if (hold_kick != seen_kick) begin
      seen_kick <= hold_kick;
      hold_left <= HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (energy_q.size() == 0) begin
        if (error_count < ERR_PRINT_MAX)
          $error("energy: expected none, actual %0d", m_tdata[ENERGY_W-1:0]);
        error_count++;
      end else begin
        expected_energy = energy_q.pop_front();
        energies_checked++;
        if (m_tdata[ENERGY_W-1:0] !== expected_energy) begin
          if (error_count < ERR_PRINT_MAX)
            $error("energy: expected %0d, actual %0d", expected_energy,
                   m_tdata[ENERGY_W-1:0]);
          error_count++;
        end
        if (m_tdata[OUT_TW-1:ENERGY_W] !== '0) begin
          if (error_count < ERR_PRINT_MAX)
            $error("energy pad: expected 0, actual %0h", m_tdata[OUT_TW-1:ENERGY_W]);
          error_count++;
        end
      end
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= TDATA_W'({$urandom(), $urandom()});
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r, l};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    energy_q.push_back(stereo_energy(l, r));
    pairs_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (energy_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_coefs(input coef_set_t c);
    int i;
    for (i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= c[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      active_coefs[i] = c[i];
    end
    // the spare index must leave every coefficient alone
    cfg_index <= REG_UNUSED;
    cfg_data <= $urandom();
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    coef_loads++;
  endtask

  task automatic test_default_response();
    set_idling(0, 0);
    send_pair('0, '0);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MIN, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SB'(1), SB'(-1));
    send_pair('0, '0);
    send_pair('0, '0);
    send_pair(SB'(-1), SB'(1));
    drain();
  endtask

  task automatic test_coef_extremes();
    coef_set_t c;
    load_coefs(coef_set_t'({NUM_REGS{COEF_MAX}}));
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair('0, '0);
    send_pair(SB'(1), SB'(-1));
    drain();
    load_coefs(coef_set_t'({NUM_REGS{COEF_MIN}}));
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair('0, '0);
    send_pair(SB'(1), SB'(-1));
    drain();
    load_coefs('0);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair('0, '0);
    drain();
    // half-unit gain on odd samples lands exactly on rounding ties
    c = '0;
    c[REG_SHELF_B0] = COEF_HALF;
    load_coefs(c);
    send_pair(SB'(1), SB'(-1));
    send_pair(SB'(3), SB'(-3));
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    drain();
  endtask

  task automatic test_random_traffic();
    int mode;
    int set_n;
    int n;
    for (mode = 0; mode < RANDOM_MODES; mode++) begin
      case (mode)
        0: set_idling(0, 0);
        1: set_idling(57, 0);
        2: set_idling(0, 57);
        default: set_idling(31, 31);
      endcase
      for (set_n = 0; set_n < SETS_PER_MODE; set_n++) begin
        load_coefs(make_coefs((set_n + mode) % 4));
        for (n = 0; n < PAIRS_PER_SET; n++) send_pair(rand_sample(), rand_sample());
        drain();
      end
    end
  endtask

  task automatic test_output_backpressure();
    int n;
    load_coefs(make_coefs(1));
    set_idling(0, 0);
    hold_kick <= hold_kick + 1;
    for (n = 0; n < 16; n++) send_pair(rand_sample(), rand_sample());
    drain();
  endtask

  task automatic test_sender_pause();
    int n;
    load_coefs(default_coefs());
    set_idling(31, 31);
    for (n = 0; n < 20; n++) send_pair(rand_sample(), rand_sample());
    drain();
    for (n = 0; n < 20; n++) send_pair(rand_sample(), rand_sample());
    drain();
  endtask

  initial begin
    int i;
    active_coefs = default_coefs();
    for (i = 0; i < 4; i++) begin
      shelf_in_hist[i] = '0;
      shelf_out_hist[i] = '0;
      hp_out_hist[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_default_response();
    test_coef_extremes();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();
    drain();
    repeat (END_SETTLE) @(posedge clk);
    $display("summary: %0d stereo pairs sent, %0d energies checked, %0d coefficient loads",
             pairs_sent, energies_checked, coef_loads);
    $display("summary: defaults, rails, ties, random sets, output hold-off and idle mixes");
    if (error_count == 0 && energy_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/kwl_pkg.sv
rtl/core/kwl_ctrl.sv
rtl/core/kwl_datapath.sv
rtl/core/k_weighting_loudness_prefilter.sv
tb/sv/tb.sv
